>>> rtl/rscev_pkg.sv
// Shared constants, codes and types of the routing step cost evaluator.
package rscev_pkg;

	// Penalty table geometry.
	localparam int TABLE_ENTRIES = 64;
	localparam int TBL_AW        = $clog2(TABLE_ENTRIES);

	// Field widths.
	localparam int COST_W   = 64;
	localparam int USED_W   = 7;
	localparam int SLOT_W   = 6;
	localparam int LAYER_W  = 8;
	localparam int COORD_W  = 32;
	localparam int EDIR_W   = 2;
	localparam int SDIR_W   = 3;
	localparam int PDIR_W   = 4;
	localparam int CFG_IW   = 3;

	// Five terms of at most 64 bits each fit in 67 bits without loss.
	localparam int ACC_W    = COST_W + 3;

	// Base cost, base surcharge, turn cost and turn surcharge.
	localparam int TERM_W   = 3;
	localparam logic [TERM_W-1:0] TERM_COUNT = TERM_W'(4);

	localparam logic [PDIR_W-1:0] NO_PRIOR_DIR = PDIR_W'(8);

	// Item operation codes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IW-1:0] CFG_ORTH_COST    = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] CFG_DIAG_COST    = CFG_IW'(1);
	localparam logic [CFG_IW-1:0] CFG_TURN_COST    = CFG_IW'(2);
	localparam logic [CFG_IW-1:0] CFG_ORTH_EXTRA   = CFG_IW'(3);
	localparam logic [CFG_IW-1:0] CFG_DIAG_EXTRA   = CFG_IW'(4);
	localparam logic [CFG_IW-1:0] CFG_TURN_EXTRA   = CFG_IW'(5);
	localparam logic [CFG_IW-1:0] CFG_ENTRIES_USED = CFG_IW'(6);

	// Work queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [LAYER_W-1:0]        layer;
		logic signed [COORD_W-1:0] col;
		logic signed [COORD_W-1:0] row;
		logic [EDIR_W-1:0]         dir;
	} key_t;

	typedef struct packed {
		key_t              key;
		logic [COST_W-1:0] penalty;
	} entry_t;

	// One classified item as it waits in the queue.
	typedef struct packed {
		logic              op;
		logic [SLOT_W-1:0] slot;
		key_t              key;
		logic              diag;
		logic              turn;
		logic [COST_W-1:0] penalty;
	} item_t;

	typedef struct packed {
		logic [COST_W-1:0] orth_cost;
		logic [COST_W-1:0] diag_cost;
		logic [COST_W-1:0] turn_cost;
		logic [COST_W-1:0] orth_extra;
		logic [COST_W-1:0] diag_extra;
		logic [COST_W-1:0] turn_extra;
		logic [USED_W-1:0] entries_used;
	} cost_cfg_t;

	typedef struct packed {
		logic idle;
		logic in_scan;
	} bk_status_t;

endpackage

>>> rtl/routing_step_cost_evaluator.sv
// A write lands in the table when the idle back end takes it. A query raises done after its
// scan, which reads one table entry per cycle; entries_used counts past 64 act as 64.
// The back end takes a new item only while idle, so a query finishes before the next begins;
// a two-beat queue lets start beats be taken while the back end works, and busy rises only
// when that queue is full. Results appear on done for one cycle and cannot be stalled.
// Reset clears control and configuration registers; the penalty table is not cleared.
module routing_step_cost_evaluator (
	input  logic                          clk,
	input  logic                          arst_n,
	// Command channel.
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic [rscev_pkg::SLOT_W-1:0]  slot,
	input  logic [rscev_pkg::LAYER_W-1:0] layer_id,
	input  logic signed [rscev_pkg::COORD_W-1:0] lattice_col,
	input  logic signed [rscev_pkg::COORD_W-1:0] lattice_row,
	input  logic [rscev_pkg::EDIR_W-1:0]  edge_dir,
	input  logic [rscev_pkg::SDIR_W-1:0]  step_dir,
	input  logic [rscev_pkg::PDIR_W-1:0]  prior_dir,
	input  logic [rscev_pkg::COST_W-1:0]  penalty_value,
	// Result channel.
	output logic                          done,
	output logic [rscev_pkg::COST_W-1:0]  step_cost,
	output logic                          cost_overflow,
	output logic                          penalty_hit,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rscev_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [rscev_pkg::COST_W-1:0]  cfg_data
);
	import rscev_pkg::*;

	cost_cfg_t  cfg_q;
	logic       cfg_wr;

	logic       push;
	item_t      push_item;
	logic       queue_full;
	logic       queue_empty;
	logic       pop;
	item_t      pop_item;
	bk_status_t bk_status;

	// The register file takes a write beat in every cycle. Software must write it only while
	// no query is in flight; the block does not enforce it. The back end reads them directly.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_ORTH_COST:    cfg_q.orth_cost    <= cfg_data;
				CFG_DIAG_COST:    cfg_q.diag_cost    <= cfg_data;
				CFG_TURN_COST:    cfg_q.turn_cost    <= cfg_data;
				CFG_ORTH_EXTRA:   cfg_q.orth_extra   <= cfg_data;
				CFG_DIAG_EXTRA:   cfg_q.diag_extra   <= cfg_data;
				CFG_TURN_EXTRA:   cfg_q.turn_extra   <= cfg_data;
				CFG_ENTRIES_USED: cfg_q.entries_used <= cfg_data[USED_W-1:0];
				// Indexes past the register list are dropped.
				default: ;
			endcase
		end
	end

	// The front end decides per beat whether it is a table write or a query, and for
	// a query whether the move is diagonal and whether it bends.
	rscev_front u_front (
		.start         (start),
		.busy          (busy),
		.op            (op),
		.slot          (slot),
		.layer_id      (layer_id),
		.lattice_col   (lattice_col),
		.lattice_row   (lattice_row),
		.edge_dir      (edge_dir),
		.step_dir      (step_dir),
		.prior_dir     (prior_dir),
		.penalty_value (penalty_value),
		.queue_full    (queue_full),
		.push          (push),
		.push_item     (push_item)
	);

	// Items keep their order through the queue, so a table write always lands
	// before any query accepted after it.
	rscev_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (queue_empty)
	);

	// The back end owns the penalty table. A query scans the valid slots in order
	// while the four profile terms are summed into a 67-bit accumulator, one per
	// cycle; the matching penalty is added last and the overflow check follows.
	rscev_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.queue_empty   (queue_empty),
		.pop_item      (pop_item),
		.pop           (pop),
		.status        (bk_status),
		.done          (done),
		.step_cost     (step_cost),
		.cost_overflow (cost_overflow),
		.penalty_hit   (penalty_hit)
	);

	// A result strobe is a single-cycle pulse: the back end returns to idle after it.
	ap_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// An overflowing sum is reported with a zero cost.
	ap_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cost_overflow) |-> (step_cost == '0))
		else $error("cost not zero on overflow");

	// No result can leave while the table scan is still running.
	ap_no_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.in_scan |-> !done)
		else $error("result strobe during table scan");

	// An idle back end pops queued work in the same cycle.
	ap_idle_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(bk_status.idle && !queue_empty) |-> pop)
		else $error("back end idle with queued work");

endmodule

>>> rtl/rscev_front.sv
// Front end: accepts command beats and classifies them for the back end.
module rscev_front (
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic [rscev_pkg::SLOT_W-1:0]  slot,
	input  logic [rscev_pkg::LAYER_W-1:0] layer_id,
	input  logic signed [rscev_pkg::COORD_W-1:0] lattice_col,
	input  logic signed [rscev_pkg::COORD_W-1:0] lattice_row,
	input  logic [rscev_pkg::EDIR_W-1:0]  edge_dir,
	input  logic [rscev_pkg::SDIR_W-1:0]  step_dir,
	input  logic [rscev_pkg::PDIR_W-1:0]  prior_dir,
	input  logic [rscev_pkg::COST_W-1:0]  penalty_value,
	input  logic                          queue_full,
	output logic                          push,
	output rscev_pkg::item_t              push_item
);
	import rscev_pkg::*;

	assign busy = queue_full;
	assign push = start && !queue_full;

	always_comb begin
		push_item.op        = op;
		push_item.slot      = slot;
		push_item.key.layer = layer_id;
		push_item.key.col   = lattice_col;
		push_item.key.row   = lattice_row;
		push_item.key.dir   = edge_dir;
		// Odd move codes are the diagonals.
		push_item.diag      = step_dir[0];
		// Any given incoming direction other than the move itself is a bend.
		push_item.turn      = (prior_dir != NO_PRIOR_DIR) &&
		                      (prior_dir != {1'b0, step_dir});
		push_item.penalty   = penalty_value;
	end

endmodule

>>> rtl/rscev_queue.sv
// Short work queue between the front end and the back end.
module rscev_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rscev_pkg::item_t push_item,
	output logic             full,
	input  logic             pop,
	output rscev_pkg::item_t pop_item,
	output logic             empty
);
	import rscev_pkg::*;

	item_t             slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/rscev_back.sv
// Back end: penalty table, linear lookup and exact cost summation.
module rscev_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rscev_pkg::cost_cfg_t         cfg,
	input  logic                         queue_empty,
	input  rscev_pkg::item_t             pop_item,
	output logic                         pop,
	output rscev_pkg::bk_status_t        status,
	output logic                         done,
	output logic [rscev_pkg::COST_W-1:0] step_cost,
	output logic                         cost_overflow,
	output logic                         penalty_hit
);
	import rscev_pkg::*;

	typedef enum logic [2:0] {
		BK_IDLE   = 3'b001,
		BK_SCAN   = 3'b010,
		BK_FINISH = 3'b100
	} bk_state_t;

	bk_state_t         state_q;
	entry_t            tbl_mem_q [TABLE_ENTRIES];
	entry_t            rd_entry_s1;
	logic              rd_vld_s1;
	logic [USED_W-1:0] addr_q;
	logic [TERM_W-1:0] term_q;
	logic [ACC_W-1:0]  acc_q;
	logic [COST_W-1:0] pen_q;
	logic              hit_q;
	key_t              key_q;
	logic              diag_q;
	logic              turn_q;
	logic              done_q;
	logic [COST_W-1:0] step_cost_q;
	logic              cost_overflow_q;
	logic              penalty_hit_q;

	logic [USED_W-1:0] used;
	logic              wr_en;
	logic              start_query;
	logic              match;
	logic              issue;
	logic              scan_end;
	logic              term_add;
	logic [COST_W-1:0] term_val;
	logic              finish;
	logic [ACC_W-1:0]  sum;
	logic              ovf;
	entry_t            wr_entry;

	// Counts above the table size cover the whole table.
	assign used = (cfg.entries_used > USED_W'(TABLE_ENTRIES)) ?
	              USED_W'(TABLE_ENTRIES) : cfg.entries_used;

	assign pop         = (state_q == BK_IDLE) && !queue_empty;
	assign wr_en       = pop && (pop_item.op == OP_WRITE) &&
	                     ({1'b0, pop_item.slot} < (SLOT_W + 1)'(TABLE_ENTRIES));
	assign start_query = pop && (pop_item.op == OP_QUERY);

	assign wr_entry.key     = pop_item.key;
	assign wr_entry.penalty = pop_item.penalty;

	// First matching slot wins; no further read is issued once a slot matches.
	assign match    = rd_vld_s1 && (rd_entry_s1.key == key_q);
	assign issue    = (state_q == BK_SCAN) && !match && (addr_q < used);
	assign scan_end = (state_q == BK_SCAN) && (match || ((addr_q >= used) && !rd_vld_s1));

	assign term_add = (state_q != BK_IDLE) && (term_q != TERM_COUNT);

	always_comb begin
		case (term_q[1:0])
			2'd0:    term_val = diag_q ? cfg.diag_cost : cfg.orth_cost;
			2'd1:    term_val = diag_q ? cfg.diag_extra : cfg.orth_extra;
			2'd2:    term_val = turn_q ? cfg.turn_cost : '0;
			default: term_val = turn_q ? cfg.turn_extra : '0;
		endcase
	end

	assign finish = (state_q == BK_FINISH) && (term_q == TERM_COUNT);
	assign sum    = acc_q + ACC_W'(pen_q);
	assign ovf    = (|sum[ACC_W-1:COST_W]) || (&sum[COST_W-1:0]);

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem_q[TBL_AW'(pop_item.slot)] <= wr_entry;
		end
		if (issue) begin
			rd_entry_s1 <= tbl_mem_q[addr_q[TBL_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (start_query) begin
			key_q  <= pop_item.key;
			diag_q <= pop_item.diag;
			turn_q <= pop_item.turn;
			acc_q  <= '0;
		end else if (term_add) begin
			acc_q  <= acc_q + ACC_W'(term_val);
		end
		if (scan_end) begin
			hit_q <= match;
			pen_q <= match ? rd_entry_s1.penalty : '0;
		end
		if (finish) begin
			step_cost_q     <= ovf ? '0 : sum[COST_W-1:0];
			cost_overflow_q <= ovf;
			penalty_hit_q   <= hit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			rd_vld_s1 <= 1'b0;
			addr_q    <= '0;
			term_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q    <= finish;
			rd_vld_s1 <= issue;
			if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
			if (term_add) begin
				term_q <= term_q + 1'b1;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (start_query) begin
						addr_q  <= '0;
						term_q  <= '0;
						state_q <= BK_SCAN;
					end
				end
				BK_SCAN: begin
					if (scan_end) begin
						state_q <= BK_FINISH;
					end
				end
				BK_FINISH: begin
					if (finish) begin
						state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	assign status.idle    = (state_q == BK_IDLE);
	assign status.in_scan = (state_q == BK_SCAN);

	assign done          = done_q;
	assign step_cost     = step_cost_q;
	assign cost_overflow = cost_overflow_q;
	assign penalty_hit   = penalty_hit_q;

endmodule
